FILE: src/bci_pkg.sv
// ============================================================================
// Battery charge indicator package
// Shared types, fixed-point constants and small helper functions for the
// battery charge indicator and its shared multiplier.
// ============================================================================
package bci_pkg;

    // Field widths
    localparam int AdcBits  = 12;
    localparam int VoltBits = 19;        // Q16 volts with three integer bits
    localparam int TimeBits = 32;

    // Configuration register indexes
    localparam logic [2:0] CFG_UPDATE_INTERVAL = 3'd0;
    localparam logic [2:0] CFG_INSTANT_RISE    = 3'd1;
    localparam logic [2:0] CFG_CUMULATIVE_RISE = 3'd2;
    localparam logic [2:0] CFG_FULL_VOLTAGE    = 3'd3;
    localparam logic [2:0] CFG_CLEAR_VOLTAGE   = 3'd4;
    localparam logic [2:0] CFG_INSTANT_HOLD    = 3'd5;
    localparam logic [2:0] CFG_CUMULATIVE_HOLD = 3'd6;
    localparam logic [2:0] CFG_REFERENCE_WIN   = 3'd7;

    // Divider scale 6.6 V full range in Q16, and the converter full-scale code
    localparam logic [18:0] DIV_SCALE  = 19'd432538;
    localparam logic [30:0] ADC_FULL   = 31'd4095;

    // Division by 4095 as a multiply by floor(2^43 / 4095) plus one correction
    localparam int          VoltRecipShift = 43;
    localparam logic [31:0] VOLT_RECIP = 32'(((64'd1 << VoltRecipShift)) / 64'd4095);

    // Division by 100 as a multiply by floor(2^32 / 100) plus one correction
    localparam int          FiltRecipShift = 32;
    localparam logic [31:0] FILT_RECIP = 32'(((64'd1 << FiltRecipShift)) / 64'd100);
    localparam logic [25:0] FILT_DIVISOR = 26'd100;
    localparam logic [25:0] FILT_ROUND   = 26'd50;
    localparam logic [31:0] FILT_OLD_WEIGHT = 32'd85;
    localparam logic [31:0] FILT_NEW_WEIGHT = 32'd15;

    // Reference drop margin of 0.01 V and the level window 3.30 V to 4.20 V
    localparam logic [19:0] DROP_MARGIN = 20'd655;
    localparam logic [18:0] LEVEL_MIN   = 19'd216269;
    localparam logic [18:0] LEVEL_MAX   = 19'd275251;
    localparam logic [15:0] LEVEL_SPAN  = 16'd58982;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RECIP,
        ST_VOLTS,
        ST_MUL_V,
        ST_SUM,
        ST_RECIP_F,
        ST_FILT,
        ST_RULES_A,
        ST_RULES_B
    } state_t;

    // One input transaction
    typedef struct packed {
        logic [AdcBits-1:0]  adc_code;
        logic [TimeBits-1:0] now_ms;
    } in_item_t;

    // One result transaction
    typedef struct packed {
        logic [VoltBits-1:0] filtered_voltage;
        logic                charging;
        logic [3:0]          level_tenths;
        logic [2:0]          icon_step;
    } out_item_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic        en;
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    // Rounded charge level in tenths: level >= k when 20*d >= (2k-1)*span.
    function automatic logic [3:0] level_of(input logic [VoltBits-1:0] v);
        logic [15:0] d;
        logic [20:0] d20;
        logic [3:0]  lvl;
        if (v < LEVEL_MIN) begin
            d = 16'd0;
        end else if (v > LEVEL_MAX) begin
            d = LEVEL_SPAN;
        end else begin
            d = 16'(v - LEVEL_MIN);
        end
        d20 = {1'b0, d, 4'b0} + {3'b0, d, 2'b0};
        lvl = 4'd0;
        for (int k = 1; k <= 10; k++) begin
            if (d20 >= 21'((2 * k - 1) * int'(LEVEL_SPAN))) begin
                lvl = 4'(k);
            end
        end
        return lvl;
    endfunction

    // Five-step battery icon from the level.
    function automatic logic [2:0] icon_of(input logic [3:0] lvl);
        logic [2:0] icon;
        if (lvl >= 4'd8) begin
            icon = 3'd4;
        end else if (lvl >= 4'd5) begin
            icon = 3'd3;
        end else if (lvl >= 4'd3) begin
            icon = 3'd2;
        end else if (lvl >= 4'd1) begin
            icon = 3'd1;
        end else begin
            icon = 3'd0;
        end
        return icon;
    endfunction

endpackage

FILE: src/bci_mul.sv
// ============================================================================
// Battery charge indicator shared multiplier
// One 32 x 32 multiplier with a registered 64-bit product, used in turn by
// the scaling, reciprocal and filter-weight steps of the sequencer.
// ============================================================================
module bci_mul (
    input  logic              clk,
    input  bci_pkg::mul_req_t req,
    output logic [63:0]       prod
);

    logic [63:0] prod_reg;

    // Product is registered so the step after the request sees it.
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= {32'b0, req.a} * {32'b0, req.b};
        end
    end

    assign prod = prod_reg;

endmodule

FILE: src/battery_charge_indicator.sv
// ============================================================================
// Battery charge indicator
// Filters battery converter samples to Q16 volts, tracks charging by rise
// and full-voltage rules with hold timers, and reports level and icon.
// ============================================================================
// A sample runs through every state (the seeding one skips the filter steps, a
// dropped one leaves after scaling) and is taken only while idle; its result
// waits while the output stalls. A filtered one makes five passes through the
// single shared 32 x 32 multiplier (scale, reciprocal, two weights, reciprocal).
// Reset: asynchronous and active low; control and configuration registers
// return to their defaults and the filter is unseeded until the next sample.
module battery_charge_indicator (
    input  logic                clk,
    input  logic                rst_n,
    // Input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  bci_pkg::in_item_t   in_data,
    // Output channel
    output logic                out_valid,
    input  logic                out_stall,
    output bci_pkg::out_item_t  out_data,
    // Configuration write port
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [18:0]         cfg_data
);

    // Configuration registers
    logic [15:0] update_interval_reg;
    logic [16:0] instant_rise_reg;
    logic [16:0] cumulative_rise_reg;
    logic [18:0] full_voltage_reg;
    logic [18:0] clear_voltage_reg;
    logic [15:0] instant_hold_reg;
    logic [15:0] cumulative_hold_reg;
    logic [15:0] reference_win_reg;

    // Sequencer and persistent state
    bci_pkg::state_t state_reg, state_next;
    logic        seeded_reg, seeded_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [18:0] filt_reg, filt_next;
    logic [18:0] prior_reg, prior_next;
    logic [18:0] ref_reg, ref_next;
    logic [31:0] ref_time_reg, ref_time_next;
    logic [31:0] hold_reg, hold_next;
    logic        flag_reg, flag_next;
    logic        out_valid_reg, out_valid_next;

    // Working registers for one transaction
    logic [11:0] code_reg, code_next;
    logic [31:0] now_reg, now_next;
    logic [30:0] num_reg, num_next;
    logic [18:0] volts_reg, volts_next;
    logic [25:0] acc_reg, acc_next;
    bci_pkg::out_item_t out_data_reg, out_data_next;

    // Shared multiplier
    bci_pkg::mul_req_t mul_req;
    logic [63:0]       prod;

    // Combinational helpers
    logic [31:0] since_last;
    logic [18:0] q_volts;
    logic [30:0] r_volts;
    logic [18:0] volts_val;
    logic [18:0] q_filt;
    logic [25:0] r_filt;
    logic [20:0] delta;
    logic        instant_hit;
    logic        drop_hit;
    logic [18:0] ref_a;
    logic [31:0] ref_time_a;
    logic [31:0] age;
    logic        window_hit;
    logic [20:0] rise;
    logic        cum_hit;
    logic        flag_b;
    logic [31:0] hold_b;
    logic [31:0] hold_left;
    logic [3:0]  level;
    logic        out_free;

    bci_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign in_stall  = (state_reg != bci_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration writes; values are kept modulo their register width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            update_interval_reg <= 16'd1000;
            instant_rise_reg    <= 17'd655;
            cumulative_rise_reg <= 17'd5243;
            full_voltage_reg    <= 19'd270008;
            clear_voltage_reg   <= 19'd265421;
            instant_hold_reg    <= 16'd8000;
            cumulative_hold_reg <= 16'd12000;
            reference_win_reg   <= 16'd5000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bci_pkg::CFG_UPDATE_INTERVAL: update_interval_reg <= cfg_data[15:0];
                bci_pkg::CFG_INSTANT_RISE:    instant_rise_reg    <= cfg_data[16:0];
                bci_pkg::CFG_CUMULATIVE_RISE: cumulative_rise_reg <= cfg_data[16:0];
                bci_pkg::CFG_FULL_VOLTAGE:    full_voltage_reg    <= cfg_data;
                bci_pkg::CFG_CLEAR_VOLTAGE:   clear_voltage_reg   <= cfg_data;
                bci_pkg::CFG_INSTANT_HOLD:    instant_hold_reg    <= cfg_data[15:0];
                bci_pkg::CFG_CUMULATIVE_HOLD: cumulative_hold_reg <= cfg_data[15:0];
                bci_pkg::CFG_REFERENCE_WIN:   reference_win_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Control and persistent state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bci_pkg::ST_IDLE;
            seeded_reg    <= 1'b0;
            last_time_reg <= 32'd0;
            filt_reg      <= 19'd0;
            prior_reg     <= 19'd0;
            ref_reg       <= 19'd0;
            ref_time_reg  <= 32'd0;
            hold_reg      <= 32'd0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            last_time_reg <= last_time_next;
            filt_reg      <= filt_next;
            prior_reg     <= prior_next;
            ref_reg       <= ref_next;
            ref_time_reg  <= ref_time_next;
            hold_reg      <= hold_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers carry payload only and need no reset.
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        now_reg      <= now_next;
        num_reg      <= num_next;
        volts_reg    <= volts_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // Arithmetic shared by the steps.
    always_comb
    begin
        since_last = now_reg - last_time_reg;

        // Quotient by 4095 is exact or one short; one compare fixes it.
        q_volts   = prod[bci_pkg::VoltRecipShift +: 19];
        r_volts   = num_reg - ({q_volts, 12'b0} - {12'b0, q_volts});
        volts_val = q_volts + {18'b0, (r_volts >= bci_pkg::ADC_FULL)};

        // Quotient by 100, with the same single correction.
        q_filt = prod[bci_pkg::FiltRecipShift +: 19];
        r_filt = acc_reg - ({1'b0, q_filt, 6'b0} + {2'b0, q_filt, 5'b0} + {5'b0, q_filt, 2'b0});

        // Instant rise, reference drop and reference window.
        delta       = {2'b0, filt_reg} - {2'b0, prior_reg};
        instant_hit = $signed(delta) >= $signed({4'b0, instant_rise_reg});
        drop_hit    = ({1'b0, filt_reg} + bci_pkg::DROP_MARGIN) < {1'b0, ref_reg};
        ref_a       = drop_hit ? filt_reg : ref_reg;
        ref_time_a  = drop_hit ? now_reg : ref_time_reg;
        age         = now_reg - ref_time_a;
        window_hit  = $signed({age[31], age}) > $signed({17'b0, reference_win_reg});

        // Cumulative rise, full voltage and expiry of the hold.
        rise      = {2'b0, filt_reg} - {2'b0, ref_reg};
        cum_hit   = $signed(rise) >= $signed({4'b0, cumulative_rise_reg});
        hold_b    = cum_hit ? (now_reg + {16'b0, cumulative_hold_reg}) : hold_reg;
        hold_left = now_reg - hold_b;
        flag_b    = flag_reg || cum_hit || (filt_reg >= full_voltage_reg);
        if (flag_b && !hold_left[31] && (filt_reg <= clear_voltage_reg))
        begin
            flag_b = 1'b0;
        end
        level = bci_pkg::level_of(filt_reg);
    end

    // Sequencer: next state, register updates and multiplier requests.
    always_comb
    begin
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        last_time_next = last_time_reg;
        filt_next      = filt_reg;
        prior_next     = prior_reg;
        ref_next       = ref_reg;
        ref_time_next  = ref_time_reg;
        hold_next      = hold_reg;
        flag_next      = flag_reg;
        code_next      = code_reg;
        now_next       = now_reg;
        num_next       = num_reg;
        volts_next     = volts_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        mul_req        = '0;

        case (state_reg)
            bci_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    code_next  = in_data.adc_code;
                    now_next   = in_data.now_ms;
                    state_next = bci_pkg::ST_SCALE;
                end
            end

            bci_pkg::ST_SCALE:
            begin
                // Samples inside the update interval are dropped once seeded.
                if (seeded_reg && (since_last < {16'b0, update_interval_reg}))
                begin
                    state_next = bci_pkg::ST_IDLE;
                end
                else
                begin
                    last_time_next = now_reg;
                    mul_req.en     = 1'b1;
                    mul_req.a      = {20'b0, code_reg};
                    mul_req.b      = {13'b0, bci_pkg::DIV_SCALE};
                    state_next     = bci_pkg::ST_RECIP;
                end
            end

            bci_pkg::ST_RECIP:
            begin
                num_next   = prod[30:0];
                mul_req.en = 1'b1;
                mul_req.a  = {1'b0, prod[30:0]};
                mul_req.b  = bci_pkg::VOLT_RECIP;
                state_next = bci_pkg::ST_VOLTS;
            end

            bci_pkg::ST_VOLTS:
            begin
                if (!seeded_reg)
                begin
                    // The first sample seeds the filter and the trackers.
                    filt_next     = volts_val;
                    prior_next    = volts_val;
                    ref_next      = volts_val;
                    ref_time_next = now_reg;
                    hold_next     = now_reg;
                    flag_next     = 1'b0;
                    seeded_next   = 1'b1;
                    state_next    = bci_pkg::ST_RULES_A;
                end
                else
                begin
                    volts_next = volts_val;
                    mul_req.en = 1'b1;
                    mul_req.a  = {13'b0, filt_reg};
                    mul_req.b  = bci_pkg::FILT_OLD_WEIGHT;
                    state_next = bci_pkg::ST_MUL_V;
                end
            end

            bci_pkg::ST_MUL_V:
            begin
                acc_next   = prod[25:0] + bci_pkg::FILT_ROUND;
                mul_req.en = 1'b1;
                mul_req.a  = {13'b0, volts_reg};
                mul_req.b  = bci_pkg::FILT_NEW_WEIGHT;
                state_next = bci_pkg::ST_SUM;
            end

            bci_pkg::ST_SUM:
            begin
                acc_next   = acc_reg + prod[25:0];
                state_next = bci_pkg::ST_RECIP_F;
            end

            bci_pkg::ST_RECIP_F:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = {6'b0, acc_reg};
                mul_req.b  = bci_pkg::FILT_RECIP;
                state_next = bci_pkg::ST_FILT;
            end

            bci_pkg::ST_FILT:
            begin
                filt_next  = q_filt + {18'b0, (r_filt >= bci_pkg::FILT_DIVISOR)};
                state_next = bci_pkg::ST_RULES_A;
            end

            bci_pkg::ST_RULES_A:
            begin
                prior_next = filt_reg;
                if (instant_hit)
                begin
                    flag_next = 1'b1;
                    hold_next = now_reg + {16'b0, instant_hold_reg};
                end
                if (window_hit)
                begin
                    ref_next      = filt_reg;
                    ref_time_next = now_reg;
                end
                else
                begin
                    ref_next      = ref_a;
                    ref_time_next = ref_time_a;
                end
                state_next = bci_pkg::ST_RULES_B;
            end

            bci_pkg::ST_RULES_B:
            begin
                // Commit only when the output register can take the result.
                if (out_free)
                begin
                    flag_next = flag_b;
                    hold_next = hold_b;
                    if (cum_hit)
                    begin
                        ref_next      = filt_reg;
                        ref_time_next = now_reg;
                    end
                    out_data_next.filtered_voltage = filt_reg;
                    out_data_next.charging         = flag_b;
                    out_data_next.level_tenths     = level;
                    out_data_next.icon_step        = bci_pkg::icon_of(level);
                    out_valid_next = 1'b1;
                    state_next     = bci_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bci_pkg::ST_IDLE;
            end
        endcase
    end

    // An accepted transaction always starts the scaling step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == bci_pkg::ST_SCALE))
        else $error("accepted transaction did not start processing");

    // Once seeded the filter stays seeded until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(seeded_reg))
        else $error("seeded flag fell without reset");

    // Every result carries a voltage in range and a level within tenths.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.filtered_voltage <= bci_pkg::DIV_SCALE) &&
                       (out_data.level_tenths <= 4'd10)))
        else $error("result voltage or level out of range");

    // The top icon step agrees with the level it was derived from.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.icon_step == 3'd4) == (out_data.level_tenths >= 4'd8)))
        else $error("icon step disagrees with level");

endmodule
